### sv/swing_leg_path_generator_defines.svh
// Assertion macros for the swing leg path generator
`ifndef SWING_LEG_PATH_GENERATOR_DEFINES_SVH
`define SWING_LEG_PATH_GENERATOR_DEFINES_SVH

// implication checked on every edge outside reset
`define SLPG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked with the consequent in the cycle after the antecedent
`define SLPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/slpg_pkg.sv
// Shared types and constants for the swing leg path generator
package slpg_pkg;
	localparam int unsigned DW = 32;
	localparam int unsigned IDX_W = 4;
	localparam longint unsigned QONE = 64'd1073741824;
	localparam longint unsigned QHALF = 64'd536870912;

	typedef enum logic [0:0] {
		REG_BASE_HEIGHT = 1'b0,
		REG_APEX_HEIGHT = 1'b1
	} reg_idx_t;

	// one classified path request
	typedef struct packed {
		logic signed [DW-1:0] start;
		logic                 span_neg;
		logic [DW:0]          span_mag;
		logic                 degen;
	} path_req_t;
endpackage

### sv/slpg_front.sv
// Front end: takes a path request and classifies its span
module slpg_front (
	input  logic signed [31:0]  start_pos,
	input  logic signed [31:0]  end_pos,
	output slpg_pkg::path_req_t req
);
	import slpg_pkg::*;

	logic signed [DW:0] span;

	always_comb begin
		span = {end_pos[DW-1], end_pos} - {start_pos[DW-1], start_pos};
		req.start = start_pos;
		req.span_neg = span[DW];
		req.span_mag = span[DW] ? (~span + 1'b1) : span;
		req.degen = (span == '0);
	end
endmodule

### sv/slpg_queue.sv
// Two-entry queue between front end and sample sequencer
module slpg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  slpg_pkg::path_req_t push_data,
	input  logic                pop,
	output slpg_pkg::path_req_t pop_data,
	output logic                full,
	output logic                empty
);
	import slpg_pkg::*;

	path_req_t  slot0_q, slot1_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign pop_data = rd_ptr_q ? slot1_q : slot0_q;

	always_ff @(posedge clk) begin
		if (push && !wr_ptr_q) begin
			slot0_q <= push_data;
		end
		if (push && wr_ptr_q) begin
			slot1_q <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### sv/slpg_back.sv
// Back end: steps through the samples of a path and evaluates each one
module slpg_back #(
	parameter int SAMPLE_COUNT = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  slpg_pkg::path_req_t q_data,
	output logic                q_pop,
	input  logic signed [31:0]  base_height,
	input  logic signed [31:0]  apex_height,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  horiz_pos,
	output logic signed [31:0]  height,
	output logic [3:0]          sample_index,
	output logic                degenerate,
	output logic                last
);
	import slpg_pkg::*;

	localparam int CW = $clog2(SAMPLE_COUNT);
	localparam longint unsigned N = SAMPLE_COUNT - 1;
	localparam longint unsigned DEN = N * N * N * N * N;
	localparam logic [CW-1:0] K_LAST = CW'(SAMPLE_COUNT - 1);

	// Q1.30 unsigned position and height weight per sample, fixed at elaboration
	logic [30:0] p_tab [SAMPLE_COUNT];
	logic [30:0] w_tab [SAMPLE_COUNT];

	for (genvar k = 0; k < SAMPLE_COUNT; k++) begin : g_tab
		localparam longint unsigned KL = k;
		localparam longint unsigned K3 = KL * KL * KL;
		localparam longint unsigned NUM = 10 * K3 * N * N + 6 * K3 * KL * KL - 15 * K3 * KL * N;
		localparam longint unsigned PV = (NUM * QONE + DEN / 2) / DEN;
		localparam longint unsigned WV = (4 * PV * (QONE - PV) + QHALF) >> 30;
		assign p_tab[k] = PV[30:0];
		assign w_tab[k] = WV[30:0];
	end

	// sequencer
	logic          busy_q;
	path_req_t     req_q;
	logic [CW-1:0] k_q;
	logic          adv;
	logic          issue;
	logic          load;

	// stage registers
	logic                 v_s1, v_s2, v_s3;
	logic [CW-1:0]        k_s1, k_s2;
	logic                 last_s1, last_s2;
	logic                 degen_s1, degen_s2;
	logic signed [31:0]   start_s1, start_s2;
	logic                 xneg_s1, xneg_s2;
	logic                 hneg_s1, hneg_s2;
	logic [32:0]          xmag_s1, hmag_s1;
	logic [30:0]          p_s1, w_s1;
	logic [63:0]          xprod_s2, hprod_s2;

	logic signed [32:0]   hdiff;
	logic [63:0]          xr, hr;
	logic [31:0]          xoff;
	logic signed [35:0]   hoff, hsum;
	logic signed [31:0]   hsat;
	logic [CW+3:0]        k_ext;

	assign adv = !(v_s3 && out_stall);
	assign issue = busy_q && adv;
	assign load = !q_empty && (!busy_q || (issue && k_q == K_LAST));
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (issue) begin
				if (k_q == K_LAST) begin
					busy_q <= 1'b0;
				end
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_q <= q_data;
		end
	end

	assign hdiff = {apex_height[31], apex_height} - {base_height[31], base_height};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1 <= k_q;
			last_s1 <= (k_q == K_LAST);
			degen_s1 <= req_q.degen;
			start_s1 <= req_q.start;
			xneg_s1 <= req_q.span_neg;
			xmag_s1 <= req_q.span_mag;
			hneg_s1 <= hdiff[32];
			hmag_s1 <= hdiff[32] ? 33'(~hdiff + 1'b1) : 33'(hdiff);
			p_s1 <= p_tab[k_q];
			w_s1 <= w_tab[k_q];

			k_s2 <= k_s1;
			last_s2 <= last_s1;
			degen_s2 <= degen_s1;
			start_s2 <= start_s1;
			xneg_s2 <= xneg_s1;
			hneg_s2 <= hneg_s1;
			xprod_s2 <= {31'd0, xmag_s1} * {33'd0, p_s1};
			hprod_s2 <= {31'd0, hmag_s1} * {33'd0, w_s1};

			horiz_pos <= start_s2 + xoff;
			height <= degen_s2 ? base_height : hsat;
			sample_index <= k_ext[3:0];
			degenerate <= degen_s2;
			last <= last_s2;
		end
	end

	// round half away from zero on the magnitude, then restore the sign
	always_comb begin
		xr = (xprod_s2 + QHALF) >> 30;
		hr = (hprod_s2 + QHALF) >> 30;
		xoff = xneg_s2 ? (~xr[31:0] + 1'b1) : xr[31:0];
		hoff = hneg_s2 ? (~{2'b00, hr[33:0]} + 1'b1) : {2'b00, hr[33:0]};
		hsum = {{4{base_height[31]}}, base_height} + hoff;
		if (hsum > 36'sd2147483647) begin
			hsat = 32'sh7fffffff;
		end else if (hsum < -36'sd2147483648) begin
			hsat = 32'sh80000000;
		end else begin
			hsat = hsum[31:0];
		end
		k_ext = {4'd0, k_s2};
	end

	assign out_valid = v_s3;
endmodule

### sv/swing_leg_path_generator.sv
// Swing leg path generator top level: config registers, front end, queue and back end
//
// Each accepted start/end pair yields SAMPLE_COUNT beats of a minimum-jerk horizontal
// path with a parabolic height profile (Q16.16). Samples leave at one per cycle while
// out_stall is low; the back end's sequencer sets the rate. A two-entry queue holds
// requests while the back end works, so the next path follows without a gap. Height
// parameters are written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
module swing_leg_path_generator #(
	parameter int SAMPLE_COUNT = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] start_pos,
	input  logic signed [31:0] end_pos,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] horiz_pos,
	output logic signed [31:0] height,
	output logic [3:0]         sample_index,
	output logic               degenerate,
	output logic               last
);
	import slpg_pkg::*;
	`include "swing_leg_path_generator_defines.svh"

	localparam logic [3:0] LAST_IDX = 4'((SAMPLE_COUNT - 1) % 16);

	logic signed [31:0] base_q, apex_q;
	path_req_t          req, q_data;
	logic               q_full, q_empty, q_pop, push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'sd1966080;
			apex_q <= 32'sd1638400;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BASE_HEIGHT: base_q <= cfg_data;
				REG_APEX_HEIGHT: apex_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	slpg_front u_front (
		.start_pos(start_pos),
		.end_pos(end_pos),
		.req(req)
	);

	slpg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(req),
		.pop(q_pop),
		.pop_data(q_data),
		.full(q_full),
		.empty(q_empty)
	);

	slpg_back #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(q_data),
		.q_pop(q_pop),
		.base_height(base_q),
		.apex_height(apex_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.horiz_pos(horiz_pos),
		.height(height),
		.sample_index(sample_index),
		.degenerate(degenerate),
		.last(last)
	);

	// the closing beat of a path carries the final sample number
	`SLPG_ASSERT(a_last_index, clk, arst_n, (out_valid && last) |-> (sample_index == LAST_IDX), "last beat with wrong sample index")
	// samples of one path leave without bubbles
	`SLPG_ASSERT_NEXT(a_no_gap, clk, arst_n, out_valid && !out_stall && !last, out_valid, "gap inside a path")
	// queue never pops when empty
	`SLPG_ASSERT(a_pop_ok, clk, arst_n, q_pop |-> !q_empty, "pop from empty queue")
endmodule
